/* hdl/sha256_stream_hasher_assert.svh */
// assertion macros shared by the hasher modules
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// implication checked every clock, quiet during reset
`define SHS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/shs_pkg.sv */
// ----------------------------------------------------------------------------
// shs_pkg
// shared types and constants of the streaming sha-256 hasher
// ----------------------------------------------------------------------------
`default_nettype none
package shs_pkg;

    localparam int QDEPTH = 4;

    // front to back queue entry
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } shs_item_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[r];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

/* hdl/shs_front.sv */
// ----------------------------------------------------------------------------
// shs_front
// input stage and item queue between the stream port and the compression core
// ----------------------------------------------------------------------------
`default_nettype none
module shs_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire shs_pkg::shs_item_t in_item,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output shs_pkg::shs_item_t     q_item
);
    import shs_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    shs_item_t        mem [QDEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             push, pop;

    // items with neither flag set do nothing and are dropped here
    assign in_ready = (cnt_reg != (AW+1)'(QDEPTH));
    assign push     = in_valid && in_ready && (in_item.byte_valid || in_item.end_of_message);
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem[rptr_reg];

    always_comb begin
        wptr_next = push ? wptr_reg + AW'(1) : wptr_reg;
        rptr_next = pop  ? rptr_reg + AW'(1) : rptr_reg;
        cnt_next  = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= in_item;
        end
    end

`include "sha256_stream_hasher_assert.svh"
    `SHS_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, cnt_reg < (AW+1)'(QDEPTH))
    `SHS_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, cnt_reg != '0)
    `SHS_ASSERT_NEXT(a_cnt_step, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule
`default_nettype wire

/* hdl/shs_core.sv */
// ----------------------------------------------------------------------------
// shs_core
// block packing, padding, one-round-per-cycle compression and digest output
// ----------------------------------------------------------------------------
`default_nettype none
module shs_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire shs_pkg::shs_item_t q_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             out_word,
    output logic [2:0]              out_num,
    output logic                    out_last
);
    import shs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1; // block store to schedule
    localparam logic [2:0] ST_RND  = 3'd2; // 64 rounds
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_PAD  = 3'd4; // write pad bytes one a cycle
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  st_reg, st_next;
    logic [31:0] blk [16];  // block store, first byte of a word in its top bits
    logic [31:0] w [16];
    logic [31:0] h [8];
    logic [31:0] a, b, c, d, e, f, g, hh;
    logic [60:0] total_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  pidx_reg;
    logic        fin_reg;   // padding in progress for this message
    logic        two_reg;   // length block still owed after this compression
    logic        lead_reg;  // 0x80 still owed at the start of the length block
    logic [63:0] bits_reg;
    logic [2:0]  onum_reg;
    logic [31:0] ld_word;
    logic [31:0] wt, s0, s1, t1, t2;
    logic [7:0]  pad_byte;
    logic        blk_full;  // this item's byte completes the block
    logic [5:0]  end_pos;   // where 0x80 goes on an end item

    assign q_ready   = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_OUT);
    assign out_word  = h[onum_reg];
    assign out_num   = onum_reg;
    assign out_last  = (onum_reg == 3'd7);

    assign blk_full = q_item.byte_valid && (total_reg[5:0] == 6'd63);
    assign end_pos  = total_reg[5:0] + {5'd0, q_item.byte_valid};

    assign ld_word = blk[rnd_reg[3:0]];

    always_comb begin
        s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
        s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
        wt = w[0];
        t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(rnd_reg) + wt;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        // pad byte at pidx: 0x80 when the block was full, zeros, length in last eight bytes
        if (pidx_reg >= 6'd56 && !two_reg) begin
            pad_byte = bits_reg[8*(63 - pidx_reg) +: 8];
        end else if (lead_reg && pidx_reg == 6'd0) begin
            pad_byte = 8'h80;
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (q_valid) begin
                if (blk_full) st_next = ST_LOAD;
                else if (q_item.end_of_message)
                    st_next = (end_pos == 6'd63) ? ST_LOAD : ST_PAD;
            end
            ST_LOAD: if (rnd_reg == 6'd15) st_next = ST_RND;
            ST_RND:  if (rnd_reg == 6'd63) st_next = ST_ADD;
            ST_ADD:  st_next = two_reg ? ST_PAD : (fin_reg ? ST_OUT : ST_PAD);
            ST_PAD:  if (pidx_reg == 6'd63) st_next = ST_LOAD;
            ST_OUT:  if (out_ready && onum_reg == 3'd7) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
        if (st_reg == ST_ADD && !fin_reg) st_next = ST_IDLE;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            total_reg <= '0;
            rnd_reg   <= '0;
            pidx_reg  <= '0;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            lead_reg  <= 1'b0;
            onum_reg  <= '0;
            for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
        end else begin
            st_reg <= st_next;
            unique case (st_reg)
                ST_IDLE: begin
                    rnd_reg <= '0;
                    if (q_valid) begin
                        logic [60:0] tn;
                        tn = q_item.byte_valid ? total_reg + 61'd1 : total_reg;
                        total_reg <= tn;
                        if (q_item.end_of_message) begin
                            fin_reg  <= 1'b1;
                            bits_reg <= {tn, 3'b000};
                            // 0x80 at tn%64; rest of block after it
                            pidx_reg <= tn[5:0] + 6'd1;
                            two_reg  <= blk_full || (tn[5:0] >= 6'd56);
                            lead_reg <= blk_full;
                        end
                    end
                end
                ST_LOAD: rnd_reg <= (rnd_reg == 6'd15) ? 6'd0 : rnd_reg + 6'd1;
                ST_RND:  rnd_reg <= rnd_reg + 6'd1;
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        h[i] <= h[i] + ((i == 0) ? a : (i == 1) ? b : (i == 2) ? c :
                                        (i == 3) ? d : (i == 4) ? e : (i == 5) ? f :
                                        (i == 6) ? g : hh);
                    end
                    if (two_reg) begin
                        two_reg  <= 1'b0;
                        pidx_reg <= 6'd0;
                    end
                end
                ST_PAD: begin
                    if (pidx_reg == 6'd63) rnd_reg <= '0;
                    pidx_reg <= pidx_reg + 6'd1;
                end
                ST_OUT: if (out_ready) begin
                    onum_reg <= onum_reg + 3'd1;
                    if (onum_reg == 3'd7) begin
                        fin_reg   <= 1'b0;
                        total_reg <= '0;
                        for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
                    end
                end
                default: ;
            endcase
        end
    end

    // block store and pad writes, one byte lane each
    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && q_valid) begin
            if (q_item.byte_valid) begin
                blk[total_reg[5:2]][8*(3 - total_reg[1:0]) +: 8] <= q_item.msg_byte;
                if (q_item.end_of_message && total_reg[5:0] != 6'd63)
                    blk[end_pos[5:2]][8*(3 - end_pos[1:0]) +: 8] <= 8'h80;
            end else if (q_item.end_of_message) begin
                blk[total_reg[5:2]][8*(3 - total_reg[1:0]) +: 8] <= 8'h80;
            end
        end else if (st_reg == ST_PAD) begin
            blk[pidx_reg[5:2]][8*(3 - pidx_reg[1:0]) +: 8] <= pad_byte;
        end
    end

    // schedule shift register and working variables
    always_ff @(posedge aclk) begin
        unique case (st_reg)
            ST_LOAD: begin
                for (int i = 0; i < 15; i++) w[i] <= w[i+1];
                w[15] <= ld_word;
                {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3],
                                               h[4], h[5], h[6], h[7]};
            end
            ST_RND: begin
                for (int i = 0; i < 15; i++) w[i] <= w[i+1];
                w[15] <= s1 + w[9] + s0 + w[0];
                hh <= g; g <= f; f <= e; e <= d + t1;
                d <= c; c <= b; b <= a; a <= t1 + t2;
            end
            default: ;
        endcase
    end

`include "sha256_stream_hasher_assert.svh"
    `SHS_ASSERT_IMP(a_out_only_fin, aclk, aresetn, out_valid, fin_reg)
    `SHS_ASSERT_IMP(a_idle_no_two, aclk, aresetn, st_reg == ST_IDLE, !two_reg)
    `SHS_ASSERT_NEXT(a_round_done, aclk, aresetn, st_reg == ST_RND && rnd_reg == 6'd63,
                     st_reg == ST_ADD)

endmodule
`default_nettype wire

/* hdl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// streaming sha-256: bytes in, eight digest words out per message
// ----------------------------------------------------------------------------
// usage
//   s_ side: one transfer per item; tdata = msg_byte, tuser = byte_valid,
//   tlast = end_of_message. a transfer with both flags low is dropped.
//   m_ side: eight transfers per message, word 0 first, tlast on word 7.
// timing
//   a four-entry item queue decouples the port from the compression core.
//   a byte that does not fill a block is only stored in the core; the 64th
//   byte of a block is accepted, then the block is loaded into the schedule,
//   64 rounds run and the result is added; no new item is taken meanwhile.
//   end of message: pad bytes are written one a cycle and one or two
//   compressions run, then the eight output words follow.
// reset
//   aresetn low empties the queue, clears the byte count and loads the initial chaining words.
// stall
//   m_axis_tready low holds the current digest word; the core accepts no
//   new item until all eight words are transferred, the queue fills meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // msg_byte
    input  wire logic        s_axis_tuser,   // byte_valid
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // digest_word[31:0], word_number[34:32], zeros
    output logic             m_axis_tlast    // final_word
);
    import shs_pkg::*;

    shs_item_t  in_item, q_item;
    logic       q_valid, q_ready;
    logic [31:0] word;
    logic [2:0]  num;

    assign in_item = '{msg_byte: s_axis_tdata, byte_valid: s_axis_tuser,
                       end_of_message: s_axis_tlast};

    shs_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    shs_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_word(word), .out_num(num), .out_last(m_axis_tlast)
    );

    // digest words come out in order
    assign m_axis_tdata = {5'd0, num, word};

endmodule
`default_nettype wire
